// ===== hw/rtl/ilp_pkg.sv =====
// Shared types, constants and character codes for the integer literal parser.
package ilp_pkg;

  // String length limit and accumulator width
  localparam int MAX_CHARS  = 32;
  localparam int VALUE_BITS = 32;
  localparam int POS_W      = $clog2(MAX_CHARS + 1);

  // Character codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_F_LO = 8'h66;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_F_UP = 8'h46;
  localparam logic [3:0] HEX_TEN = 4'hA;

  // Result kinds
  localparam logic [2:0] KIND_EMPTY  = 3'd0;
  localparam logic [2:0] KIND_DEC    = 3'd1;
  localparam logic [2:0] KIND_HEX    = 3'd2;
  localparam logic [2:0] KIND_BADHEX = 3'd3;
  localparam logic [2:0] KIND_OCT    = 3'd4;

  // Parse mode of the current string
  typedef enum logic [2:0] {
    MODE_START,
    MODE_DEC,
    MODE_ZERO,
    MODE_HEX,
    MODE_BADHEX,
    MODE_OCT
  } mode_t;

  // Per-string parse state
  typedef struct packed {
    logic [VALUE_BITS-1:0] acc;
    logic [POS_W-1:0]      position;
    mode_t                 mode;
    logic                  stopped;
  } state_t;

  // Channel payloads
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  kind;
  } out_t;

endpackage

// ===== hw/rtl/ilp_step.sv =====
// Combinational next-state and result logic for one character.
module ilp_step import ilp_pkg::*; (
  input  state_t     state,
  input  in_t        item,
  output state_t     state_next,
  output logic       emit,
  output out_t       result
);

  logic                  take;
  logic                  is_dec;
  logic                  is_hex_lo;
  logic                  is_hex_up;
  logic [3:0]            digit;
  logic [3:0]            hex_digit;
  logic [VALUE_BITS-1:0] dec_acc;
  state_t                upd;

  // Classify the character
  always_comb begin
    take      = (item.ch != CH_NUL) && (state.position < POS_W'(MAX_CHARS));
    is_dec    = (item.ch >= CH_0) && (item.ch <= CH_9);
    is_hex_lo = (item.ch >= CH_A_LO) && (item.ch <= CH_F_LO);
    is_hex_up = (item.ch >= CH_A_UP) && (item.ch <= CH_F_UP);
    digit     = 4'(item.ch - CH_0);
    if (is_hex_lo) begin
      hex_digit = 4'(item.ch - CH_A_LO) + HEX_TEN;
    end else if (is_hex_up) begin
      hex_digit = 4'(item.ch - CH_A_UP) + HEX_TEN;
    end else begin
      hex_digit = digit;
    end
    // acc * 10 + digit as two shifts and two adds, wrapping
    dec_acc = (state.acc << 3) + (state.acc << 1) + VALUE_BITS'(digit);
  end

  // Advance the parse state
  always_comb begin
    upd = state;
    if (take) begin
      upd.position = state.position + POS_W'(1);
      case (state.mode)
        MODE_START: begin
          if (item.ch == CH_0) begin
            upd.mode = MODE_ZERO;
            upd.acc  = '0;
          end else begin
            upd.mode = MODE_DEC;
            if (is_dec) begin
              upd.acc = dec_acc;
            end else begin
              upd.stopped = 1'b1;
            end
          end
        end
        MODE_DEC: begin
          if (!state.stopped) begin
            if (is_dec) begin
              upd.acc = dec_acc;
            end else begin
              upd.stopped = 1'b1;
            end
          end
        end
        MODE_ZERO: begin
          upd.mode = ((item.ch == CH_X_LO) || (item.ch == CH_X_UP)) ? MODE_HEX : MODE_OCT;
        end
        MODE_HEX: begin
          if (is_dec || is_hex_lo || is_hex_up) begin
            upd.acc = {state.acc[VALUE_BITS-5:0], hex_digit};
          end else begin
            upd.mode = MODE_BADHEX;
            upd.acc  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Close the string on NUL or the last flag
  always_comb begin
    emit = (item.ch == CH_NUL) || item.last;
    case (upd.mode)
      MODE_DEC:    result = '{value: 32'(upd.acc), kind: KIND_DEC};
      MODE_HEX:    result = '{value: 32'(upd.acc), kind: KIND_HEX};
      MODE_BADHEX: result = '{value: '0, kind: KIND_BADHEX};
      MODE_OCT:    result = '{value: '0, kind: KIND_OCT};
      default:     result = '{value: '0, kind: KIND_EMPTY};
    endcase
    if (emit) begin
      state_next = '{acc: '0, position: '0, mode: MODE_START, stopped: 1'b0};
    end else begin
      state_next = upd;
    end
  end

endmodule

// ===== hw/rtl/integer_literal_parser.sv =====
// Top level of the integer literal parser: input register, step logic, result register.
//
// Usage: feed one character per transaction on in_data (ch, last). A string
// ends at a NUL character or at the transaction flagged last; that transaction
// yields one result on out_data (value, kind), every other one yields none.
// Decimal strings accumulate acc*10+digit, strings opening with 0x or 0X are
// read as hex, and a leading zero followed by anything else reports octal.
// Only the first MAX_CHARS characters of a string are examined.
//
// Timing: the transaction ending a string is held in the input register, and
// its result is loaded into the result register when that register advances,
// which waits while a stalled result is held; out_valid then rises.
// Throughput: one character per cycle, but an ending character waits while a
// stalled result is held; the step logic is combinational.
//
// Reset clears the parse state and the valid flags of both registers. When
// the receiver stalls with a result held, characters that produce no result
// keep flowing; an ending character waits in the input register until the
// result register frees, and in_ready stays low while it waits.
module integer_literal_parser import ilp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic   s1_valid;
  in_t    s1_item;
  state_t state;
  state_t state_next;
  logic   emit;
  out_t   result;
  logic   s1_fire;

  ilp_step u_step (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  // Advance the input register when its result, if any, has room
  assign s1_fire  = s1_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  // Hold the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  // Update the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{acc: '0, position: '0, mode: MODE_START, stopped: 1'b0};
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // Hold the result register until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && emit) begin
      out_data <= result;
    end
  end

  // Position never runs past the character limit
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    state.position <= POS_W'(MAX_CHARS))
    else $error("position beyond character limit");

  // Ending a string returns the parse state to its start
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    s1_fire && emit |=> state.position == '0 && state.mode == MODE_START && !state.stopped)
    else $error("parse state not cleared after result");

  // Only decimal and hex modes carry a nonzero accumulator
  a_acc_zero: assert property (@(posedge clk) disable iff (rst)
    (state.mode != MODE_DEC && state.mode != MODE_HEX) |-> state.acc == '0)
    else $error("accumulator nonzero outside decimal or hex");

  // A blocked ending character never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result overwritten while stalled");

endmodule

// ===== tb/ilp_checker.sv =====
// Scoreboard for the integer literal parser: predicts each result and compares it.
`timescale 1ns / 1ps
module ilp_checker import ilp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  input  logic end_of_test,
  output int   fail_count,
  output int   pending_results
);

  // Shadow parse state of the current string
  logic [VALUE_BITS-1:0] acc;
  logic [POS_W-1:0]      char_count;
  mode_t                 parse_mode;
  logic                  dec_stopped;

  out_t expected_results[$];
  logic leftovers_checked;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_string();
    acc         = '0;
    char_count  = '0;
    parse_mode  = MODE_START;
    dec_stopped = 1'b0;
  endtask

  // Fold one decimal digit in; freeze on the first non-digit
  task automatic take_decimal(input logic [7:0] c);
    if (!dec_stopped) begin
      if (c >= CH_0 && c <= CH_9) begin
        acc = VALUE_BITS'(acc * 10 + (c - CH_0));
      end else begin
        dec_stopped = 1'b1;
      end
    end
  endtask

  // Advance the parse mode by one character
  task automatic consume_char(input logic [7:0] c);
    logic [3:0] nibble;
    logic       bad_digit;
    nibble    = '0;
    bad_digit = 1'b0;
    case (parse_mode)
      MODE_START: begin
        if (c == CH_0) begin
          parse_mode = MODE_ZERO;
          acc        = '0;
        end else begin
          parse_mode = MODE_DEC;
          take_decimal(c);
        end
      end
      MODE_DEC: begin
        take_decimal(c);
      end
      MODE_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          parse_mode = MODE_HEX;
        end else begin
          parse_mode = MODE_OCT;
        end
      end
      MODE_HEX: begin
        if (c >= CH_0 && c <= CH_9) begin
          nibble = 4'(c - CH_0);
        end else if (c >= CH_A_LO && c <= CH_F_LO) begin
          nibble = 4'(c - CH_A_LO) + HEX_TEN;
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
          nibble = 4'(c - CH_A_UP) + HEX_TEN;
        end else begin
          bad_digit = 1'b1;
        end
        if (bad_digit) begin
          parse_mode = MODE_BADHEX;
          acc        = '0;
        end else begin
          acc = {acc[VALUE_BITS-5:0], nibble};
        end
      end
      default: begin
      end
    endcase
  endtask

  // Predict the result, if any, of one input transaction
  task automatic predict_literal(input in_t t);
    out_t res;
    if (t.ch != CH_NUL && char_count < MAX_CHARS) begin
      consume_char(t.ch);
      char_count = char_count + 1'b1;
    end
    if (t.ch == CH_NUL || t.last) begin
      res.value = '0;
      case (parse_mode)
        MODE_DEC: begin
          res.value = acc;
          res.kind  = KIND_DEC;
        end
        MODE_HEX: begin
          res.value = acc;
          res.kind  = KIND_HEX;
        end
        MODE_BADHEX: begin
          res.kind = KIND_BADHEX;
        end
        MODE_OCT: begin
          res.kind = KIND_OCT;
        end
        default: begin
          res.kind = KIND_EMPTY;
        end
      endcase
      expected_results.push_back(res);
      clear_string();
    end
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      clear_string();
      expected_results.delete();
      fail_count        = 0;
      leftovers_checked = 1'b0;
    end else begin
      // Compare each result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h kind %0d",
                                    out_data.value, out_data.kind));
        end else begin
          want = expected_results.pop_front();
          if (out_data.value !== want.value) begin
            report_mismatch($sformatf("value %h, expected %h", out_data.value, want.value));
          end
          if (out_data.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, want.kind));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_literal(in_data);
      end
      // Flag predictions that never arrived
      if (end_of_test && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_results.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the integer literal parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import ilp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_CHARS  = 600;

  logic clk         = 1'b0;
  logic rst         = 1'b1;
  logic in_valid    = 1'b0;
  in_t  in_data     = '0;
  logic out_ready   = 1'b0;
  logic end_of_test = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending_results;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int chars_sent    = 0;
  int idle_cycles   = 0;
  logic [7:0] string_bytes[$];

  integer_literal_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ilp_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .end_of_test     (end_of_test),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one character, idling first at random, and hold until accepted
  task automatic send_char(input in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  // Send the buffered string, ended by a NUL or by the last flag
  task automatic send_string(input bit end_by_nul);
    int   i;
    in_t  t;
    for (i = 0; i < string_bytes.size(); i++) begin
      t.ch   = string_bytes[i];
      t.last = !end_by_nul && (i == string_bytes.size() - 1);
      send_char(t);
    end
    if (end_by_nul || string_bytes.size() == 0) begin
      t.ch   = CH_NUL;
      t.last = 1'($urandom_range(1));
      send_char(t);
    end
  endtask

  task automatic send_text(input string s, input bit end_by_nul);
    int i;
    string_bytes.delete();
    for (i = 0; i < s.len(); i++) begin
      string_bytes.push_back(s[i]);
    end
    send_string(end_by_nul);
  endtask

  // Build a mostly well-formed literal with random content, or plain noise
  task automatic send_random_string();
    int         len;
    int         pick;
    int         i;
    int         d;
    logic [7:0] c;
    string_bytes.delete();
    pick = $urandom_range(99);
    len  = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
    if (pick < 35) begin
      // decimal, sometimes frozen by a non-digit
      for (i = 0; i < len; i++) begin
        string_bytes.push_back(8'(CH_0 + $urandom_range(9)));
      end
      if ($urandom_range(3) == 0) begin
        do c = 8'($urandom_range(1, 255)); while (c >= CH_0 && c <= CH_9);
        string_bytes[$urandom_range(len - 1)] = c;
      end
    end else if (pick < 70) begin
      // hex with mixed-case digits, sometimes spoiled by a bad digit
      string_bytes.push_back(CH_0);
      string_bytes.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
      for (i = 0; i < len; i++) begin
        d = $urandom_range(15);
        if (d < 10) begin
          c = 8'(CH_0 + d);
        end else begin
          c = 8'(($urandom_range(1) ? CH_A_LO : CH_A_UP) + d - 10);
        end
        string_bytes.push_back(c);
      end
      if ($urandom_range(4) == 0) begin
        do c = 8'($urandom_range(1, 255));
        while ((c >= CH_0 && c <= CH_9) || (c >= CH_A_LO && c <= CH_F_LO) ||
               (c >= CH_A_UP && c <= CH_F_UP));
        string_bytes[$urandom_range(2, len + 1)] = c;
      end
    end else if (pick < 80) begin
      // leading zero followed by anything but x
      string_bytes.push_back(CH_0);
      do c = 8'($urandom_range(1, 255)); while (c == CH_X_LO || c == CH_X_UP);
      string_bytes.push_back(c);
      for (i = 0; i < len - 1; i++) begin
        string_bytes.push_back(8'($urandom_range(1, 255)));
      end
    end else if (pick < 86) begin
      // lone zero or empty
      if ($urandom_range(1)) begin
        string_bytes.push_back(CH_0);
      end
    end else begin
      for (i = 0; i < len; i++) begin
        string_bytes.push_back(8'($urandom_range(1, 255)));
      end
    end
    send_string(1'($urandom_range(1)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    recv_idle_pct = 68;
    // Directed strings: each kind and the corner cases of the format
    send_text("", 1'b1);
    send_text("0", 1'b0);
    send_text("0X", 1'b0);
    send_text("0xfF9", 1'b0);
    send_text("07", 1'b1);
    send_text("0xg1", 1'b0);
    send_text("a5", 1'b0);
    send_text("9:3", 1'b1);
    string_bytes.delete();
    string_bytes.push_back(8'hFF);
    send_string(1'b0);

    while (chars_sent < PHASE_CHARS) begin
      send_random_string();
    end
    send_idle_pct = 68;
    recv_idle_pct = 14;
    while (chars_sent < 2 * PHASE_CHARS) begin
      send_random_string();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (chars_sent < 3 * PHASE_CHARS) begin
      send_random_string();
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    repeat (2) @(posedge clk);
    while (pending_results != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
